// ===== rtl/mpq_pkg.sv =====
// Shared types and constants for the two-key max priority queue.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package mpq_pkg;

    // Store geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ROLL_W   = 16;
    localparam int MARKS_W  = 10;

    // Operation codes
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_PEEK = 2'd1,
        OP_POP  = 2'd2,
        OP_LOAD = 2'd3
    } op_t;

    // One stored entry
    typedef struct packed {
        logic [MARKS_W-1:0] marks;
        logic [ROLL_W-1:0]  roll;
    } entry_t;

    // Input item
    typedef struct packed {
        op_t                op;
        logic [ROLL_W-1:0]  roll;
        logic [MARKS_W-1:0] marks;
    } item_t;

    // Result item
    typedef struct packed {
        logic               empty_res;
        logic [ROLL_W-1:0]  top_roll;
        logic [MARKS_W-1:0] top_marks;
        logic               overflow;
    } result_t;

    // Store access request from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

// ===== rtl/mpq_store.sv =====
// Entry store: one write port, one read port with registered read data.
// Depends on mpq_pkg.
`timescale 1ns / 1ps

module mpq_store (
    input  logic              clk,
    input  mpq_pkg::mem_req_t req,
    output mpq_pkg::entry_t   rd_data
);
    import mpq_pkg::*;

    entry_t mem [CAPACITY];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

// ===== rtl/mpq_rank_cmp.sv =====
// Shared rank comparator: higher marks first, lower roll on equal marks.
// Depends on mpq_pkg.
`timescale 1ns / 1ps

module mpq_rank_cmp (
    input  mpq_pkg::entry_t a,
    input  mpq_pkg::entry_t b,
    output logic            a_above
);
    import mpq_pkg::*;

    // Strictly above: equal entries never shift past each other
    always_comb
    begin
        a_above = (a.marks > b.marks) || ((a.marks == b.marks) && (a.roll < b.roll));
    end

endmodule

// ===== rtl/max_priority_queue_two_key_unit.sv =====
// Top level of the two-key max priority queue: sequencer, entry count and result outputs.
// Depends on mpq_pkg, mpq_store and mpq_rank_cmp.
//
//   channel   | handshake           | payload
//   ----------+---------------------+-----------------------------
//   command   | start, busy         | item   (op, roll, marks)
//   result    | result_valid strobe | result (empty_res, top_roll,
//             |                     |         top_marks, overflow)
//
// Peek and pop read the top slot and then show their result. An insert moves entries
// up one slot at a time and then writes the new entry into the freed slot; a push
// then also reports. Each move is a read and a compare-write pair on the single store
// port pair, driven through the one rank comparator. A dropped insert reports like a peek.
// Reset clears the count and the sequencer; the store needs no clearing. Results cannot
// be held off: each strobe lasts one cycle.
`timescale 1ns / 1ps

module max_priority_queue_two_key_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mpq_pkg::item_t   item,
    output logic             result_valid,
    output mpq_pkg::result_t result
);
    import mpq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SHF_RD  = 6'b000010,
        S_SHF_CMP = 6'b000100,
        S_PLACE   = 6'b001000,
        S_RPT_RD  = 6'b010000,
        S_RPT_OUT = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    entry_t            ent_reg, ent_next;
    logic              push_reg, push_next;
    logic              drop_reg, drop_next;
    mem_req_t          req;
    entry_t            rd_data;
    logic              shift_up;
    logic              full;

    mpq_store u_store (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    mpq_rank_cmp u_cmp (
        .a       (rd_data),
        .b       (ent_reg),
        .a_above (shift_up)
    );

    assign busy = (state_reg != S_IDLE);
    assign full = (count_reg == CNT_W'(CAPACITY));

    // Sequence one item
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        ent_next   = ent_reg;
        push_next  = push_reg;
        drop_next  = drop_reg;
        req        = '0;
        req.wdata  = ent_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ent_next.roll  = item.roll;
                    ent_next.marks = item.marks;
                    push_next      = (item.op == OP_PUSH);
                    drop_next      = 1'b0;
                    if (item.op inside {OP_PUSH, OP_LOAD})
                    begin
                        if (full)
                        begin
                            drop_next  = 1'b1;
                            state_next = S_RPT_RD;
                        end
                        else
                        begin
                            pos_next   = count_reg[ADDR_W-1:0];
                            state_next = (count_reg == '0) ? S_PLACE : S_SHF_RD;
                        end
                    end
                    else
                    begin
                        if (item.op == OP_POP && count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        state_next = S_RPT_RD;
                    end
                end
            end
            S_SHF_RD:
            begin
                req.re     = 1'b1;
                req.raddr  = pos_reg - ADDR_W'(1);
                state_next = S_SHF_CMP;
            end
            S_SHF_CMP:
            begin
                req.we    = 1'b1;
                req.waddr = pos_reg;
                if (shift_up)
                begin
                    // Move the higher-ranked entry up one slot
                    req.wdata  = rd_data;
                    pos_next   = pos_reg - ADDR_W'(1);
                    state_next = (pos_reg == ADDR_W'(1)) ? S_PLACE : S_SHF_RD;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = push_reg ? S_RPT_RD : S_IDLE;
                end
            end
            S_PLACE:
            begin
                req.we     = 1'b1;
                req.waddr  = pos_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = push_reg ? S_RPT_RD : S_IDLE;
            end
            S_RPT_RD:
            begin
                req.re     = 1'b1;
                req.raddr  = ADDR_W'(count_reg - CNT_W'(1));
                state_next = S_RPT_OUT;
            end
            S_RPT_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            push_reg  <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            push_reg  <= push_next;
            drop_reg  <= drop_next;
        end
    end

    // Hold the entry being inserted and its slot
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        ent_reg <= ent_next;
    end

    // Drive the result strobe and fields
    always_comb
    begin
        result_valid     = (state_reg == S_RPT_OUT);
        result.overflow  = drop_reg;
        result.empty_res = (count_reg == '0);
        if (count_reg == '0)
        begin
            result.top_roll  = '0;
            result.top_marks = '0;
        end
        else
        begin
            result.top_roll  = rd_data.roll;
            result.top_marks = rd_data.marks;
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not start the sequencer");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.overflow) |-> full)
        else $error("overflow reported with room in the store");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.empty_res) |-> (result.top_roll == '0 && result.top_marks == '0))
        else $error("empty result carries a nonzero top");

    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

endmodule
